// ===== src/mfrq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and the 16-way priority encoder of the ready queue.
package mfrq_pkg;

  localparam int ID_W   = 6;   // thread id and thread out ports
  localparam int PRIO_W = 6;   // requested level and level out ports
  localparam int ACT_W  = 2;
  localparam int ERR_W  = 2;

  localparam int GROUP_SIZE = 16;  // levels per group in the level search
  localparam int GIDX_W     = 4;   // index within a group, and group index

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CHANGE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd3;

  localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_QUEUED = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY  = 2'd2;

  // {any, index of highest set bit}
  function automatic logic [GIDX_W:0] prio_enc(input logic [GROUP_SIZE-1:0] v);
    logic [GIDX_W:0] r;
    r = '0;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (v[i]) begin
        r = {1'b1, GIDX_W'(i)};
      end
    end
    return r;
  endfunction

endpackage

// ===== src/mfrq_level_enc.sv =====
`timescale 1ns / 1ps
// Two-stage search for the highest non-empty level: group pick, then bit pick.
module mfrq_level_enc import mfrq_pkg::*; #(
  parameter int NUM_LEVELS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [NUM_LEVELS-1:0]         nonempty_i,
  output logic                          found_o,
  output logic [$clog2(NUM_LEVELS)-1:0] level_o
);

  localparam int LW   = $clog2(NUM_LEVELS);
  localparam int PADW = GROUP_SIZE * GROUP_SIZE;

  logic [PADW-1:0]       bits_pad;
  logic [GROUP_SIZE-1:0] grp_any;
  logic [GIDX_W:0]       grp_hit;
  logic [GIDX_W-1:0]     grp_q;
  logic                  any_q;
  logic [GROUP_SIZE-1:0] sel;
  logic [GIDX_W:0]       off_hit;

  assign bits_pad = PADW'(nonempty_i);

  always_comb begin
    for (int g = 0; g < GROUP_SIZE; g++) begin
      grp_any[g] = |bits_pad[g*GROUP_SIZE +: GROUP_SIZE];
    end
  end

  assign grp_hit = prio_enc(grp_any);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= '0;
      any_q <= 1'b0;
    end else if (load_i) begin
      grp_q <= grp_hit[GIDX_W-1:0];
      any_q <= grp_hit[GIDX_W];
    end
  end

  // second stage reads the current level bits of the group picked at the load
  assign sel     = bits_pad[grp_q*GROUP_SIZE +: GROUP_SIZE];
  assign off_hit = prio_enc(sel);
  assign found_o = any_q;
  assign level_o = LW'({grp_q, off_hit[GIDX_W-1:0]});

endmodule

// ===== src/multilevel_fifo_ready_queue_top.sv =====
`timescale 1ns / 1ps
// Top level of the multilevel FIFO ready queue: sequencer and list memories.
//
// One FIFO of threads per priority level, kept as doubly linked lists in
// small memories with registered reads, plus a stored level per thread. An
// item is taken when start is high and busy low; busy then stays high
// while a small sequencer walks the item through the memories, one read or
// read-modify-write step a cycle. A query, a duplicate insert, an insert or
// change on an out-of-range thread, a change that moves nothing and a pop
// with every level empty finish at the level lookup; an insert appends,
// reading the old tail first when the level already holds threads; a pop
// reads the head, then its links, then unlinks it; a change that relinks a
// queued thread unlinks it and then appends it at the new level.
// The steps follow the registered memory reads: level lookup, then
// head/tail and link reads, then the link writes. The highest non-empty
// level is found in two steps, a pick among groups of sixteen levels and then
// within the group. The result stays on the output ports until the next one
// and is marked by done_o, high for exactly one cycle as busy falls; the
// receiver cannot hold it off, so it must take it then. A new item may be
// started in that same cycle. After reset a clearing pass sets each stored
// thread level to the top level in turn; busy is high throughout.
module multilevel_fifo_ready_queue_top import mfrq_pkg::*; #(
  parameter int NUM_LEVELS  = 64,
  parameter int NUM_THREADS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [ID_W-1:0]   thread_id_i,
  input  logic [PRIO_W-1:0] req_level_i,
  output logic              done_o,
  output logic [ID_W-1:0]   thread_out_o,
  output logic [PRIO_W-1:0] level_out_o,
  output logic              found_o,
  output logic [ERR_W-1:0]  error_o
);

  localparam int LW = $clog2(NUM_LEVELS);
  localparam int TW = $clog2(NUM_THREADS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;  // stored level and level search ready
  localparam logic [2:0] ST_POPH  = 3'd3;  // head known, fetch its links
  localparam logic [2:0] ST_UNL   = 3'd4;  // unlink
  localparam logic [2:0] ST_APP   = 3'd5;  // append, empty level or fetch tail
  localparam logic [2:0] ST_APPW  = 3'd6;  // append behind the old tail

  // sequencer state
  logic [2:0]             state_q, state_d;
  logic [TW-1:0]          clr_q, clr_d;
  logic [ACT_W-1:0]       act_q, act_d;
  logic [ID_W-1:0]        tin_q, tin_d;
  logic [LW-1:0]          np_q, np_d;
  logic [TW-1:0]          cur_q, cur_d;
  logic [LW-1:0]          ul_q, ul_d;
  logic [LW-1:0]          app_q, app_d;
  logic                   tok_q, tok_d;
  logic [NUM_THREADS-1:0] queued_q, queued_d;
  logic [NUM_LEVELS-1:0]  nonempty_q, nonempty_d;

  // result register
  logic              res_valid_q, res_valid_d;
  logic [ID_W-1:0]   res_thread_q, res_thread_d;
  logic [PRIO_W-1:0] res_level_q, res_level_d;
  logic              res_found_q, res_found_d;
  logic [ERR_W-1:0]  res_err_q, res_err_d;

  // memories and their ports
  logic [TW-1:0] head_mem [NUM_LEVELS];
  logic [TW-1:0] tail_mem [NUM_LEVELS];
  logic [TW-1:0] next_mem [NUM_THREADS];
  logic [TW-1:0] prev_mem [NUM_THREADS];
  logic [LW-1:0] lvl_mem  [NUM_THREADS];

  logic          hd_re, hd_we, tl_re, tl_we, nx_re, nx_we, pv_re, pv_we, lv_re, lv_we;
  logic [LW-1:0] hd_ra, hd_wa, tl_ra, tl_wa;
  logic [TW-1:0] hd_wd, tl_wd;
  logic [TW-1:0] nx_ra, nx_wa, nx_wd, pv_ra, pv_wa, pv_wd;
  logic [TW-1:0] lv_ra, lv_wa;
  logic [LW-1:0] lv_wd;
  logic [TW-1:0] hd_rd_q, tl_rd_q, nx_rd_q, pv_rd_q;
  logic [LW-1:0] lv_rd_q;

  // level search
  logic          accept;
  logic          enc_found;
  logic [LW-1:0] enc_level;

  // finishing values
  logic              fin;
  logic [ID_W-1:0]   f_thread;
  logic [PRIO_W-1:0] f_level;
  logic              f_found;
  logic [ERR_W-1:0]  f_err;

  logic          t_ok;
  logic [LW-1:0] np_sat;
  logic          is_head, is_tail;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign t_ok   = (32'(thread_id_i) < NUM_THREADS);
  assign np_sat = (32'(req_level_i) > NUM_LEVELS - 1) ? LW'(NUM_LEVELS - 1)
                                                      : LW'(req_level_i);
  assign is_head = (hd_rd_q == cur_q);
  assign is_tail = (tl_rd_q == cur_q);

  mfrq_level_enc #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_level_enc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .nonempty_i (nonempty_q),
    .found_o    (enc_found),
    .level_o    (enc_level)
  );

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    act_d      = act_q;
    tin_d      = tin_q;
    np_d       = np_q;
    cur_d      = cur_q;
    ul_d       = ul_q;
    app_d      = app_q;
    tok_d      = tok_q;
    queued_d   = queued_q;
    nonempty_d = nonempty_q;

    hd_re = 1'b0; hd_ra = '0; hd_we = 1'b0; hd_wa = '0; hd_wd = '0;
    tl_re = 1'b0; tl_ra = '0; tl_we = 1'b0; tl_wa = '0; tl_wd = '0;
    nx_re = 1'b0; nx_ra = '0; nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    pv_re = 1'b0; pv_ra = '0; pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
    lv_re = 1'b0; lv_ra = '0; lv_we = 1'b0; lv_wa = '0; lv_wd = '0;

    fin      = 1'b0;
    f_thread = tin_q;
    f_level  = '0;
    f_found  = 1'b0;
    f_err    = ERR_OK;

    unique case (state_q)
      ST_CLEAR: begin
        lv_we = 1'b1;
        lv_wa = clr_q;
        lv_wd = LW'(NUM_LEVELS - 1);
        clr_d = clr_q + 1'b1;
        if (clr_q == TW'(NUM_THREADS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          act_d   = action_i;
          tin_d   = thread_id_i;
          np_d    = np_sat;
          cur_d   = TW'(thread_id_i);
          tok_d   = t_ok;
          lv_re   = t_ok;
          lv_ra   = TW'(thread_id_i);
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        unique case (act_q)
          ACT_INSERT: begin
            if (!tok_q) begin
              fin = 1'b1;
            end else if (queued_q[cur_q]) begin
              fin     = 1'b1;
              f_level = PRIO_W'(lv_rd_q);
              f_err   = ERR_QUEUED;
            end else begin
              app_d   = lv_rd_q;
              state_d = ST_APP;
            end
          end
          ACT_CHANGE: begin
            if (!tok_q) begin
              fin = 1'b1;
            end else if (np_q == lv_rd_q) begin
              fin     = 1'b1;
              f_level = PRIO_W'(lv_rd_q);
            end else begin
              lv_we = 1'b1;
              lv_wa = cur_q;
              lv_wd = np_q;
              if (queued_q[cur_q]) begin
                ul_d    = lv_rd_q;
                app_d   = np_q;
                hd_re   = 1'b1;
                hd_ra   = lv_rd_q;
                tl_re   = 1'b1;
                tl_ra   = lv_rd_q;
                nx_re   = 1'b1;
                nx_ra   = cur_q;
                pv_re   = 1'b1;
                pv_ra   = cur_q;
                state_d = ST_UNL;
              end else begin
                fin     = 1'b1;
                f_level = PRIO_W'(np_q);
              end
            end
          end
          ACT_POP: begin
            if (!enc_found) begin
              fin   = 1'b1;
              f_err = ERR_EMPTY;
            end else begin
              ul_d    = enc_level;
              hd_re   = 1'b1;
              hd_ra   = enc_level;
              tl_re   = 1'b1;
              tl_ra   = enc_level;
              state_d = ST_POPH;
            end
          end
          ACT_QUERY: begin
            fin     = 1'b1;
            f_found = enc_found;
            f_level = enc_found ? PRIO_W'(enc_level) : '0;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_POPH: begin
        cur_d   = hd_rd_q;
        nx_re   = 1'b1;
        nx_ra   = hd_rd_q;
        pv_re   = 1'b1;
        pv_ra   = hd_rd_q;
        state_d = ST_UNL;
      end
      ST_UNL: begin
        if (is_head && is_tail) begin
          nonempty_d[ul_q] = 1'b0;
        end else if (is_head) begin
          hd_we = 1'b1;
          hd_wa = ul_q;
          hd_wd = nx_rd_q;
        end else if (is_tail) begin
          tl_we = 1'b1;
          tl_wa = ul_q;
          tl_wd = pv_rd_q;
        end else begin
          nx_we = 1'b1;
          nx_wa = pv_rd_q;
          nx_wd = nx_rd_q;
          pv_we = 1'b1;
          pv_wa = nx_rd_q;
          pv_wd = pv_rd_q;
        end
        queued_d[cur_q] = 1'b0;
        if (act_q == ACT_POP) begin
          fin      = 1'b1;
          f_thread = ID_W'(cur_q);
          f_level  = PRIO_W'(ul_q);
          f_found  = 1'b1;
        end else begin
          state_d = ST_APP;
        end
      end
      ST_APP: begin
        if (nonempty_q[app_q]) begin
          tl_re   = 1'b1;
          tl_ra   = app_q;
          state_d = ST_APPW;
        end else begin
          hd_we             = 1'b1;
          hd_wa             = app_q;
          hd_wd             = cur_q;
          tl_we             = 1'b1;
          tl_wa             = app_q;
          tl_wd             = cur_q;
          nonempty_d[app_q] = 1'b1;
          queued_d[cur_q]   = 1'b1;
          fin               = 1'b1;
          f_level           = PRIO_W'(app_q);
        end
      end
      ST_APPW: begin
        nx_we           = 1'b1;
        nx_wa           = tl_rd_q;
        nx_wd           = cur_q;
        pv_we           = 1'b1;
        pv_wa           = cur_q;
        pv_wd           = tl_rd_q;
        tl_we           = 1'b1;
        tl_wa           = app_q;
        tl_wd           = cur_q;
        queued_d[cur_q] = 1'b1;
        fin             = 1'b1;
        f_level         = PRIO_W'(app_q);
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_valid_d  = fin;
    res_thread_d = res_thread_q;
    res_level_d  = res_level_q;
    res_found_d  = res_found_q;
    res_err_d    = res_err_q;
    if (fin) begin
      res_thread_d = f_thread;
      res_level_d  = f_level;
      res_found_d  = f_found;
      res_err_d    = f_err;
      state_d      = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      queued_q    <= '0;
      nonempty_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      queued_q    <= queued_d;
      nonempty_q  <= nonempty_d;
      res_valid_q <= res_valid_d;
    end
  end

  // item payload and result fields
  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    tin_q        <= tin_d;
    np_q         <= np_d;
    cur_q        <= cur_d;
    ul_q         <= ul_d;
    app_q        <= app_d;
    tok_q        <= tok_d;
    res_thread_q <= res_thread_d;
    res_level_q  <= res_level_d;
    res_found_q  <= res_found_d;
    res_err_q    <= res_err_d;
  end

  // list memories: one write, one registered read each; read data holds
  always_ff @(posedge clk_i) begin
    if (hd_we) head_mem[hd_wa] <= hd_wd;
    if (hd_re) hd_rd_q <= head_mem[hd_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tl_we) tail_mem[tl_wa] <= tl_wd;
    if (tl_re) tl_rd_q <= tail_mem[tl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (nx_re) nx_rd_q <= next_mem[nx_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (pv_re) pv_rd_q <= prev_mem[pv_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lv_we) lvl_mem[lv_wa] <= lv_wd;
    if (lv_re) lv_rd_q <= lvl_mem[lv_ra];
  end

  assign done_o       = res_valid_q;
  assign thread_out_o = res_thread_q;
  assign level_out_o  = res_level_q;
  assign found_o      = res_found_q;
  assign error_o      = res_err_q;

  // a result always follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(busy))
    else $error("result without a preceding busy cycle");

  // a successful pop leaves the popped thread off every list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_found_q && act_q == ACT_POP) |-> !queued_q[cur_q])
    else $error("popped thread still marked queued");

  // after an in-range insert the thread is queued, new or not
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && act_q == ACT_INSERT && tok_q) |-> queued_q[cur_q])
    else $error("inserted thread not marked queued");

  // empty pop only when no level holds a thread
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_err_q == ERR_EMPTY) |-> (nonempty_q == '0))
    else $error("empty pop reported with a non-empty level");

endmodule

// ===== tb/mfrq_sched_checker.sv =====
`timescale 1ns / 1ps
// Checker for the ready queue: predicts each item's result and compares on done.
module mfrq_sched_checker import mfrq_pkg::*; #(
  parameter int NUM_LEVELS  = 64,
  parameter int NUM_THREADS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [ID_W-1:0]   thread_id_i,
  input  logic [PRIO_W-1:0] req_level_i,
  input  logic              done_i,
  input  logic [ID_W-1:0]   thread_out_i,
  input  logic [PRIO_W-1:0] level_out_i,
  input  logic              found_i,
  input  logic [ERR_W-1:0]  error_i,
  output int                fails_o,
  output int                waiting_o,
  output int                items_o,
  output int                checked_o,
  output int                popped_o,
  output int                empty_pops_o,
  output int                dup_inserts_o
);

  typedef struct packed {
    logic [ID_W-1:0]   thread;
    logic [PRIO_W-1:0] level;
    logic              found;
    logic [ERR_W-1:0]  err;
  } sched_result_t;

  sched_result_t due_q[$];

  // shadow ready queue: per-level FIFOs as linked lists
  logic [ID_W-1:0]        head_of [NUM_LEVELS];
  logic [ID_W-1:0]        tail_of [NUM_LEVELS];
  logic [NUM_LEVELS-1:0]  lvl_live;
  logic [ID_W-1:0]        next_of [NUM_THREADS];
  logic [ID_W-1:0]        prev_of [NUM_THREADS];
  int                     prio_of [NUM_THREADS];
  logic [NUM_THREADS-1:0] on_list;

  function automatic void link_at_tail(int t, int lv);
    if (lvl_live[lv]) begin
      next_of[tail_of[lv]] = ID_W'(t);
      prev_of[t]           = tail_of[lv];
      tail_of[lv]          = ID_W'(t);
    end else begin
      head_of[lv]  = ID_W'(t);
      tail_of[lv]  = ID_W'(t);
      lvl_live[lv] = 1'b1;
    end
    on_list[t] = 1'b1;
  endfunction

  function automatic void unlink(int t, int lv);
    logic at_head;
    logic at_tail;
    at_head = (head_of[lv] == ID_W'(t));
    at_tail = (tail_of[lv] == ID_W'(t));
    if (at_head && at_tail) begin
      lvl_live[lv] = 1'b0;
    end else if (at_head) begin
      head_of[lv] = next_of[t];
    end else if (at_tail) begin
      tail_of[lv] = prev_of[t];
    end else begin
      next_of[prev_of[t]] = next_of[t];
      prev_of[next_of[t]] = prev_of[t];
    end
    on_list[t] = 1'b0;
  endfunction

  function automatic int top_live();
    for (int lv = NUM_LEVELS - 1; lv >= 0; lv--) begin
      if (lvl_live[lv]) begin
        return lv;
      end
    end
    return -1;
  endfunction

  function automatic sched_result_t schedule(logic [ACT_W-1:0] act, logic [ID_W-1:0] tid,
                                             logic [PRIO_W-1:0] np_in);
    sched_result_t r;
    int t;
    int np;
    int lv;
    int old;
    logic in_range;
    t        = int'(tid);
    np       = int'(np_in);
    in_range = (t < NUM_THREADS);
    if (np > NUM_LEVELS - 1) begin
      np = NUM_LEVELS - 1;
    end
    r.thread = tid;
    r.level  = '0;
    r.found  = 1'b0;
    r.err    = ERR_OK;
    case (act)
      ACT_INSERT: begin
        if (in_range) begin
          if (on_list[t]) begin
            r.err = ERR_QUEUED;
          end else begin
            link_at_tail(t, prio_of[t]);
          end
          r.level = PRIO_W'(prio_of[t]);
        end
      end
      ACT_POP: begin
        lv = top_live();
        if (lv >= 0) begin
          t = int'(head_of[lv]);
          unlink(t, lv);
          r.thread = ID_W'(t);
          r.level  = PRIO_W'(lv);
          r.found  = 1'b1;
        end else begin
          r.err = ERR_EMPTY;
        end
      end
      ACT_CHANGE: begin
        if (in_range) begin
          old = prio_of[t];
          if (np != old) begin
            prio_of[t] = np;
            if (on_list[t]) begin
              unlink(t, old);
              link_at_tail(t, np);
            end
          end
          r.level = PRIO_W'(prio_of[t]);
        end
      end
      default: begin
        lv = top_live();
        if (lv >= 0) begin
          r.level = PRIO_W'(lv);
          r.found = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fails_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t want;
    if (!rst_ni) begin
      due_q.delete();
      lvl_live      = '0;
      on_list       = '0;
      fails_o       = 0;
      waiting_o     = 0;
      items_o       = 0;
      checked_o     = 0;
      popped_o      = 0;
      empty_pops_o  = 0;
      dup_inserts_o = 0;
      for (int i = 0; i < NUM_THREADS; i++) begin
        prio_of[i] = NUM_LEVELS - 1;
      end
    end else begin
      // retire the oldest result before queueing a new item taken on this edge
      if (done_i) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got thread %0d level %0d",
                   $time, thread_out_i, level_out_i);
          fails_o++;
        end else begin
          want = due_q.pop_front();
          checked_o++;
          check_field("thread_out", want.thread, thread_out_i);
          check_field("level_out", want.level, level_out_i);
          check_field("found", want.found, found_i);
          check_field("error", want.err, error_i);
        end
      end
      if (start_i && !busy_i) begin
        want = schedule(action_i, thread_id_i, req_level_i);
        due_q.push_back(want);
        items_o++;
        if (action_i == ACT_POP && want.found) popped_o++;
        if (want.err == ERR_EMPTY) empty_pops_o++;
        if (want.err == ERR_QUEUED) dup_inserts_o++;
      end
      waiting_o = due_q.size();
    end
  end

endmodule

// ===== tb/multilevel_fifo_ready_queue_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the ready queue: stimulus, watchdog and verdict.
module multilevel_fifo_ready_queue_top_tb;
  import mfrq_pkg::*;

  localparam int NUM_LEVELS      = 64;
  localparam int NUM_THREADS     = 64;
  localparam int ITEMS_PER_PHASE = 275;
  localparam int SETTLE_CYCLES   = 8;     // worst-case item latency plus margin
  localparam int WATCHDOG_LIMIT  = 4000;  // quiet cycles tolerated

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [ACT_W-1:0]  action;
  logic [ID_W-1:0]   thread_id;
  logic [PRIO_W-1:0] req_level;
  logic              done;
  logic [ID_W-1:0]   thread_out;
  logic [PRIO_W-1:0] level_out;
  logic              found;
  logic [ERR_W-1:0]  error;

  int fails;
  int waiting;
  int items;
  int checked;
  int popped;
  int empty_pops;
  int dup_inserts;
  int idle_pct;
  int quiet_cycles;

  multilevel_fifo_ready_queue_top #(
    .NUM_LEVELS  (NUM_LEVELS),
    .NUM_THREADS (NUM_THREADS)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .action_i     (action),
    .thread_id_i  (thread_id),
    .req_level_i  (req_level),
    .done_o       (done),
    .thread_out_o (thread_out),
    .level_out_o  (level_out),
    .found_o      (found),
    .error_o      (error)
  );

  mfrq_sched_checker #(
    .NUM_LEVELS  (NUM_LEVELS),
    .NUM_THREADS (NUM_THREADS)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .action_i       (action),
    .thread_id_i    (thread_id),
    .req_level_i    (req_level),
    .done_i         (done),
    .thread_out_i   (thread_out),
    .level_out_i    (level_out),
    .found_i        (found),
    .error_i        (error),
    .fails_o        (fails),
    .waiting_o      (waiting),
    .items_o        (items),
    .checked_o      (checked),
    .popped_o       (popped),
    .empty_pops_o   (empty_pops),
    .dup_inserts_o  (dup_inserts)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: any accepted item or result clears the quiet count. Covers the
  // post-reset clearing pass and the longest sender gaps.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("multilevel_fifo_ready_queue_top_tb: done, errors");
        $finish;
      end
    end
  end

  // Offer one item and hold it until taken. An optional gap with start low
  // comes first; start is only lowered when a gap is actually taken, so a
  // back-to-back item never sees start dropped and raised in one step.
  task automatic send(logic [ACT_W-1:0] act, logic [ID_W-1:0] tid, logic [PRIO_W-1:0] np);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start     <= 1'b1;
    action    <= act;
    thread_id <= tid;
    req_level <= np;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    int r;
    logic [ACT_W-1:0]  act;
    logic [PRIO_W-1:0] np;

    rst_n     = 1'b0;
    start     = 1'b0;
    action    = ACT_QUERY;
    thread_id = '0;
    req_level = '0;
    idle_pct  = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Everything starts on the top level, so the first inserts
    // stack up there; later moves exercise unlink at head, middle and tail.
    send(ACT_QUERY,  6'd0,  6'd0);    // empty query
    send(ACT_POP,    6'd63, 6'd63);   // empty pop, echoes thread
    send(ACT_CHANGE, 6'd5,  6'd63);   // unchanged level, not queued
    send(ACT_INSERT, 6'd0,  6'd0);
    send(ACT_INSERT, 6'd0,  6'd21);   // already queued
    send(ACT_INSERT, 6'd63, 6'd0);
    send(ACT_INSERT, 6'd5,  6'd0);    // level 63 now holds 0, 63, 5
    send(ACT_CHANGE, 6'd63, 6'd0);    // middle of list, to bottom level
    send(ACT_CHANGE, 6'd0,  6'd10);   // head of list
    send(ACT_CHANGE, 6'd5,  6'd10);   // sole entry, level 63 empties
    send(ACT_QUERY,  6'd42, 6'd42);
    send(ACT_CHANGE, 6'd42, 6'd0);    // not queued, level stored only
    send(ACT_INSERT, 6'd42, 6'd63);
    send(ACT_CHANGE, 6'd5,  6'd20);   // tail of list
    send(ACT_CHANGE, 6'd5,  6'd20);   // unchanged level, queued
    send(ACT_POP,    6'd0,  6'd0);
    send(ACT_POP,    6'd0,  6'd0);
    send(ACT_QUERY,  6'd0,  6'd0);
    send(ACT_POP,    6'd0,  6'd0);
    send(ACT_POP,    6'd0,  6'd0);
    send(ACT_POP,    6'd21, 6'd42);   // empty again
    send(ACT_QUERY,  6'd63, 6'd63);

    // Random part in idling phases: none, heavy, none again (the receiver
    // cannot stall, so its phase runs flat out), then light.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       idle_pct = 88;
        3:       idle_pct = 36;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(99);
        if (r < 40)      act = ACT_INSERT;
        else if (r < 65) act = ACT_POP;
        else if (r < 90) act = ACT_CHANGE;
        else             act = ACT_QUERY;
        // bunch levels near both ends so FIFOs grow several deep
        r = $urandom_range(9);
        if (r < 3)      np = PRIO_W'($urandom_range(3));
        else if (r < 6) np = PRIO_W'(60 + $urandom_range(3));
        else            np = PRIO_W'($urandom_range(63));
        send(act, ID_W'($urandom_range(63)), np);
      end
    end
    start <= 1'b0;

    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("ran %0d items, checked %0d results", items, checked);
    $display("pops served %0d, empty pops %0d, duplicate inserts %0d",
             popped, empty_pops, dup_inserts);
    if (fails == 0 && waiting == 0) begin
      $display("multilevel_fifo_ready_queue_top_tb: done, clean");
    end else begin
      $display("multilevel_fifo_ready_queue_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/mfrq_pkg.sv
src/mfrq_level_enc.sv
src/multilevel_fifo_ready_queue_top.sv
tb/mfrq_sched_checker.sv
tb/multilevel_fifo_ready_queue_top_tb.sv
